// ===== rtl/core/eqt_pkg.sv =====
// Shared types, widths and constants for the Euler angle to quaternion block.
package eqt_pkg;

  localparam int AngleW = 18;
  localparam int QuatW  = 16;
  localparam int RotW   = 32;
  localparam int MagW   = 16;

  // Angle units are 1/512 degree once halved: a full turn is 184320 units.
  localparam int HalfTurnUnits = 92160;
  localparam int FullTurnUnits = 184320;
  localparam int QuarterUnits  = 46080;

  // z = round(mag * (pi/4 in Q30) / 23040), split as mag = 960*h + l
  // so that every product stays narrow.
  localparam int unsigned Divisor960 = 960;
  localparam int unsigned KHigh      = 35138119;
  localparam int unsigned KMid       = 36602;
  localparam int unsigned KLow       = 199;
  localparam int unsigned RoundBias  = 480;
  // floor(x / 15) = (x * Recip15) >> DivShift for x below 2993
  localparam int unsigned Recip15    = 8739;
  localparam int          DivShift   = 17;

  localparam logic signed [RotW-1:0] CordicGainQ30 = 32'sd652032874;

  localparam int AtanEntries = 24;
  localparam logic signed [RotW-1:0] AtanQ30 [AtanEntries] = '{
    32'sd843314856, 32'sd497837829, 32'sd263043836, 32'sd133525158,
    32'sd67021686,  32'sd33543515,  32'sd16775850,  32'sd8388437,
    32'sd4194282,   32'sd2097149,   32'sd1048575,   32'sd524287,
    32'sd262143,    32'sd131071,    32'sd65535,     32'sd32767,
    32'sd16383,     32'sd8191,      32'sd4095,      32'sd2047,
    32'sd1023,      32'sd511,       32'sd255,       32'sd127
  };

  // One rotator: cosine in x, sine in y, residual angle in z (all Q30).
  typedef struct packed {
    logic signed [RotW-1:0] x;
    logic signed [RotW-1:0] y;
    logic signed [RotW-1:0] z;
    logic                   flip;
  } rot_t;

  // Index 0 is bank, 1 is attitude, 2 is heading.
  localparam int AxisBank     = 0;
  localparam int AxisAttitude = 1;
  localparam int AxisHeading  = 2;

endpackage

// ===== rtl/core/eqt_angle_prep.sv =====
// Half-angle reduction and conversion to a Q30 radian seed for one axis.
module eqt_angle_prep (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [eqt_pkg::AngleW-1:0]  angle_i,
  output eqt_pkg::rot_t                      rot_o
);
  import eqt_pkg::*;

  localparam int WrapW = AngleW + 1;
  localparam int HW    = 6;
  localparam int LW    = 10;
  localparam int QLowW = 9;
  localparam int PhW   = 31;
  localparam int PlW   = 26;
  localparam int RW    = 18;

  // stage 1: wrap and fold
  logic signed [WrapW-1:0] wrap, fold;
  logic                    flip_d, neg_d;
  logic [MagW-1:0]         mag_d;
  logic [MagW-1:0]         mag_q;
  logic                    flip1_q, neg1_q;

  // stage 2: split into multiples of 960
  logic [23:0]             hprod;
  logic [MagW-1:0]         lfull;
  logic [HW-1:0]           h_d, h_q;
  logic [LW-1:0]           l_d, l_q;
  logic                    flip2_q, neg2_q;

  // stage 3: partial products
  logic [PhW-1:0]          ph_q;
  logic [PlW-1:0]          pl_q;
  logic [RW-1:0]           r_q;
  logic                    flip3_q, neg3_q;

  // stage 4: sum and sign
  logic [25:0]             qprod;
  logic [QLowW-1:0]        qlow;
  logic signed [RotW-1:0]  zmag, z_d, z_q;
  logic                    flip4_q;

  always_comb begin
    wrap   = WrapW'(angle_i);
    flip_d = 1'b0;
    if (wrap > WrapW'(HalfTurnUnits)) begin
      wrap = wrap - WrapW'(FullTurnUnits);
    end else if (wrap < -WrapW'(HalfTurnUnits)) begin
      wrap = wrap + WrapW'(FullTurnUnits);
    end
    fold = wrap;
    if (wrap > WrapW'(QuarterUnits)) begin
      fold   = wrap - WrapW'(HalfTurnUnits);
      flip_d = 1'b1;
    end else if (wrap < -WrapW'(QuarterUnits)) begin
      fold   = wrap + WrapW'(HalfTurnUnits);
      flip_d = 1'b1;
    end
    neg_d = fold[WrapW-1];
    mag_d = neg_d ? MagW'(-fold) : MagW'(fold);
  end

  always_comb begin
    hprod = 24'(mag_q[MagW-1:6]) * 24'(Recip15);
    h_d   = hprod[DivShift +: HW];
    lfull = mag_q - MagW'(h_d) * MagW'(Divisor960);
    l_d   = lfull[LW-1:0];
  end

  always_comb begin
    qprod = 26'(r_q[RW-1:6]) * 26'(Recip15);
    qlow  = qprod[DivShift +: QLowW];
    zmag  = RotW'(ph_q) + RotW'(pl_q) + RotW'(qlow);
    z_d   = neg3_q ? -zmag : zmag;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q   <= mag_d;
      flip1_q <= flip_d;
      neg1_q  <= neg_d;

      h_q     <= h_d;
      l_q     <= l_d;
      flip2_q <= flip1_q;
      neg2_q  <= neg1_q;

      ph_q    <= PhW'(h_q) * PhW'(KHigh);
      pl_q    <= PlW'(l_q) * PlW'(KMid);
      r_q     <= RW'(l_q) * RW'(KLow) + RW'(RoundBias);
      flip3_q <= flip2_q;
      neg3_q  <= neg2_q;

      z_q     <= z_d;
      flip4_q <= flip3_q;
    end
  end

  assign rot_o.x    = CordicGainQ30;
  assign rot_o.y    = '0;
  assign rot_o.z    = z_q;
  assign rot_o.flip = flip4_q;

endmodule

// ===== rtl/core/eqt_cordic_cell.sv =====
// One CORDIC micro-rotation for all three axes, registered.
module eqt_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  eqt_pkg::rot_t [2:0] rot_i,
  output eqt_pkg::rot_t [2:0] rot_o
);
  import eqt_pkg::*;

  localparam logic signed [RotW-1:0] Atan = AtanQ30[STAGE];

  rot_t [2:0] rot_d, rot_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rot_d[k].flip = rot_i[k].flip;
      // rotate toward zero residual angle
      if (!rot_i[k].z[RotW-1]) begin
        rot_d[k].x = rot_i[k].x - (rot_i[k].y >>> STAGE);
        rot_d[k].y = rot_i[k].y + (rot_i[k].x >>> STAGE);
        rot_d[k].z = rot_i[k].z - Atan;
      end else begin
        rot_d[k].x = rot_i[k].x + (rot_i[k].y >>> STAGE);
        rot_d[k].y = rot_i[k].y - (rot_i[k].x >>> STAGE);
        rot_d[k].z = rot_i[k].z + Atan;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign rot_o = rot_q;

endmodule

// ===== rtl/core/eqt_combine.sv =====
// Combines the three cosine/sine pairs into the quaternion, rounded and clamped.
module eqt_combine #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  eqt_pkg::rot_t [2:0]               rot_i,
  output logic signed [eqt_pkg::QuatW-1:0]  quat_w_o,
  output logic signed [eqt_pkg::QuatW-1:0]  quat_x_o,
  output logic signed [eqt_pkg::QuatW-1:0]  quat_y_o,
  output logic signed [eqt_pkg::QuatW-1:0]  quat_z_o
);
  import eqt_pkg::*;

  localparam int                 ProdW      = 2 * RotW;
  localparam int                 RoundShift = 60 - OUT_FRAC_BITS;
  localparam logic signed [63:0] RoundHalf  = 64'sd1 <<< (RoundShift - 1);
  localparam logic signed [63:0] OutOne     = 64'sd1 <<< OUT_FRAC_BITS;
  localparam logic signed [63:0] PairHalf   = 64'sd1 <<< 29;

  function automatic logic [QuatW-1:0] round_clamp(input logic signed [63:0] q);
    logic signed [63:0] v;
    v = (q + RoundHalf) >>> RoundShift;
    if (v > OutOne) begin
      v = OutOne;
    end else if (v < -OutOne) begin
      v = -OutOne;
    end
    return v[QuatW-1:0];
  endfunction

  function automatic logic signed [RotW-1:0] round_q30(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] t;
    t = (p + PairHalf) >>> 30;
    return t[RotW-1:0];
  endfunction

  // stage 0: undo the half-turn fold
  logic signed [RotW-1:0]  c_q [3];
  logic signed [RotW-1:0]  s_q [3];
  // stage 1: raw pair products
  logic signed [ProdW-1:0] p_cc_q, p_ss_q, p_cs_q, p_sc_q;
  logic signed [RotW-1:0]  c3_1_q, s3_1_q;
  // stage 2: pairs rounded to Q30
  logic signed [RotW-1:0]  cc_q, ss_q, cs_q, sc_q;
  logic signed [RotW-1:0]  c3_2_q, s3_2_q;
  // stage 3: Q60 products
  logic signed [ProdW-1:0] cc_c3_q, ss_s3_q, cc_s3_q, ss_c3_q;
  logic signed [ProdW-1:0] cs_c3_q, sc_s3_q, sc_c3_q, cs_s3_q;
  // stage 4: sums
  logic signed [ProdW-1:0] w_sum_q, x_sum_q, y_sum_q, z_sum_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        c_q[k] <= rot_i[k].flip ? -rot_i[k].x : rot_i[k].x;
        s_q[k] <= rot_i[k].flip ? -rot_i[k].y : rot_i[k].y;
      end

      p_cc_q <= ProdW'(c_q[AxisHeading]) * ProdW'(c_q[AxisAttitude]);
      p_ss_q <= ProdW'(s_q[AxisHeading]) * ProdW'(s_q[AxisAttitude]);
      p_cs_q <= ProdW'(c_q[AxisHeading]) * ProdW'(s_q[AxisAttitude]);
      p_sc_q <= ProdW'(s_q[AxisHeading]) * ProdW'(c_q[AxisAttitude]);
      c3_1_q <= c_q[AxisBank];
      s3_1_q <= s_q[AxisBank];

      cc_q   <= round_q30(p_cc_q);
      ss_q   <= round_q30(p_ss_q);
      cs_q   <= round_q30(p_cs_q);
      sc_q   <= round_q30(p_sc_q);
      c3_2_q <= c3_1_q;
      s3_2_q <= s3_1_q;

      cc_c3_q <= ProdW'(cc_q) * ProdW'(c3_2_q);
      ss_s3_q <= ProdW'(ss_q) * ProdW'(s3_2_q);
      cc_s3_q <= ProdW'(cc_q) * ProdW'(s3_2_q);
      ss_c3_q <= ProdW'(ss_q) * ProdW'(c3_2_q);
      cs_c3_q <= ProdW'(cs_q) * ProdW'(c3_2_q);
      sc_s3_q <= ProdW'(sc_q) * ProdW'(s3_2_q);
      sc_c3_q <= ProdW'(sc_q) * ProdW'(c3_2_q);
      cs_s3_q <= ProdW'(cs_q) * ProdW'(s3_2_q);

      w_sum_q <= cc_c3_q + ss_s3_q;
      x_sum_q <= cc_s3_q - ss_c3_q;
      y_sum_q <= cs_c3_q + sc_s3_q;
      z_sum_q <= sc_c3_q - cs_s3_q;

      quat_w_o <= round_clamp(w_sum_q);
      quat_x_o <= round_clamp(x_sum_q);
      quat_y_o <= round_clamp(y_sum_q);
      quat_z_o <= round_clamp(z_sum_q);
    end
  end

endmodule

// ===== rtl/core/euler_to_quaternion_top.sv =====
// Euler angles (Z-Y-X) to unit quaternion, fully pipelined.
// Each request passes the prep, CORDIC and combine registers in turn; a stall holds it.
// Throughput: one request and one micro-rotation per cell per cycle, unless stalled.
// A held result freezes the whole pipeline, so in_stall_o follows out_stall_i while valid.
// Reset clears only the stage valid flags; the datapath holds no state between requests.
module euler_to_quaternion_top #(
  parameter int CORDIC_STAGES = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [eqt_pkg::AngleW-1:0] bank_angle_i,
  input  logic signed [eqt_pkg::AngleW-1:0] attitude_angle_i,
  input  logic signed [eqt_pkg::AngleW-1:0] heading_angle_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [eqt_pkg::QuatW-1:0]  quat_w_o,
  output logic signed [eqt_pkg::QuatW-1:0]  quat_x_o,
  output logic signed [eqt_pkg::QuatW-1:0]  quat_y_o,
  output logic signed [eqt_pkg::QuatW-1:0]  quat_z_o
);
  import eqt_pkg::*;

  localparam int PrepLat = 4;
  localparam int CombLat = 6;
  localparam int Lat     = PrepLat + CORDIC_STAGES + CombLat;
  localparam int OutOne  = 1 << OUT_FRAC_BITS;

  logic             adv;
  logic [Lat-1:0]   valid_q, valid_d;
  rot_t [2:0]       chain [CORDIC_STAGES+1];

  // advance everything unless the result register is held
  assign adv        = !(valid_q[Lat-1] && out_stall_i);
  assign in_stall_o = !adv;
  assign valid_d    = {valid_q[Lat-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q[Lat-1];

  eqt_angle_prep u_prep_bank (
    .clk_i  (clk_i),
    .en_i   (adv),
    .angle_i(bank_angle_i),
    .rot_o  (chain[0][AxisBank])
  );

  eqt_angle_prep u_prep_attitude (
    .clk_i  (clk_i),
    .en_i   (adv),
    .angle_i(attitude_angle_i),
    .rot_o  (chain[0][AxisAttitude])
  );

  eqt_angle_prep u_prep_heading (
    .clk_i  (clk_i),
    .en_i   (adv),
    .angle_i(heading_angle_i),
    .rot_o  (chain[0][AxisHeading])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    eqt_cordic_cell #(
      .STAGE(g)
    ) u_cell (
      .clk_i(clk_i),
      .en_i (adv),
      .rot_i(chain[g]),
      .rot_o(chain[g+1])
    );
  end

  eqt_combine #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_combine (
    .clk_i   (clk_i),
    .en_i    (adv),
    .rot_i   (chain[CORDIC_STAGES]),
    .quat_w_o(quat_w_o),
    .quat_x_o(quat_x_o),
    .quat_y_o(quat_y_o),
    .quat_z_o(quat_z_o)
  );

  a_hold_freezes_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(valid_q))
    else $error("stage valid flags moved while the result was held");

  a_result_from_last_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(valid_q[Lat-2]))
    else $error("result appeared without a request in the stage before");

  a_wx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (OUT_FRAC_BITS > 14) ||
      ((quat_w_o <= OutOne) && (quat_w_o >= -OutOne) &&
       (quat_x_o <= OutOne) && (quat_x_o >= -OutOne)))
    else $error("w or x beyond unit clamp");

  a_yz_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (OUT_FRAC_BITS > 14) ||
      ((quat_y_o <= OutOne) && (quat_y_o >= -OutOne) &&
       (quat_z_o <= OutOne) && (quat_z_o >= -OutOne)))
    else $error("y or z beyond unit clamp");

endmodule
